// ===== sv/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and codes for the program image section loader.
// ----------------------------------------------------------------------------
package psl_pkg;

    // Input commands
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_EOS     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Event kinds
    localparam logic [2:0] EV_WRITE   = 3'd0;
    localparam logic [2:0] EV_DATAEND = 3'd1;
    localparam logic [2:0] EV_TEXT    = 3'd2;
    localparam logic [2:0] EV_END     = 3'd3;
    localparam logic [2:0] EV_ERROR   = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_READ    = 2'd1;
    localparam logic [1:0] ERR_SECTION = 2'd2;
    localparam logic [1:0] ERR_LARGE   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_DATA_CODE = 2'd0;
    localparam logic [1:0] REG_TEXT_CODE = 2'd1;
    localparam logic [1:0] REG_TERM_CODE = 2'd2;

    // Reset values of the section codes
    localparam logic [7:0] RST_DATA_CODE = 8'd1;
    localparam logic [7:0] RST_TEXT_CODE = 8'd2;
    localparam logic [7:0] RST_TERM_CODE = 8'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] byte_value;
        logic       read_error;
    } t_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [1:0]  error_code;
    } t_result;

    typedef struct packed {
        logic [7:0] data_code;
        logic [7:0] text_code;
        logic [7:0] term_code;
    } t_cfg;

endpackage

// ===== sv/psl_in_if.sv =====
// ----------------------------------------------------------------------------
// psl_in_if
// Input channel: one image byte or command per transfer.
// ----------------------------------------------------------------------------
interface psl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] byte_value;
    logic       read_error;

    modport source(output valid, output command, output byte_value, output read_error,
                   input ready);
    modport sink(input valid, input command, input byte_value, input read_error,
                 output ready);
endinterface

// ===== sv/psl_out_if.sv =====
// ----------------------------------------------------------------------------
// psl_out_if
// Output channel: one loader event per transfer.
// ----------------------------------------------------------------------------
interface psl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  error_code;

    modport source(output valid, output event_kind, output write_address,
                   output write_data, output error_code, input ready);
    modport sink(input valid, input event_kind, input write_address,
                 input write_data, input error_code, output ready);
endinterface

// ===== sv/psl_parser.sv =====
// ----------------------------------------------------------------------------
// psl_parser
// Section and record parser state; computes the event for one item per step.
// ----------------------------------------------------------------------------
module psl_parser #(
    parameter int MEM_BYTES = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  psl_pkg::t_item  i_item,
    input  psl_pkg::t_cfg   i_cfg,
    output logic            o_result_valid,
    output psl_pkg::t_result o_result
);

    localparam logic [16:0] MEM_LIMIT = 17'(MEM_BYTES);

    localparam logic [2:0] PH_SECTION = 3'd0;
    localparam logic [2:0] PH_SIZE_HI = 3'd1;
    localparam logic [2:0] PH_SIZE_LO = 3'd2;
    localparam logic [2:0] PH_ADDR_HI = 3'd3;
    localparam logic [2:0] PH_ADDR_LO = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_HALTED  = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_record_size, n_record_size;
    logic [16:0] r_next_address, n_next_address;
    logic [15:0] r_bytes_left, n_bytes_left;

    logic [15:0] w_size_full;
    logic [15:0] w_addr_full;
    logic [16:0] w_addr_end;
    logic [15:0] w_left_dec;

    assign w_size_full = {r_record_size[15:8], i_item.byte_value};
    assign w_addr_full = {r_next_address[15:8], i_item.byte_value};
    assign w_addr_end  = {1'b0, w_addr_full} + {1'b0, r_record_size};
    assign w_left_dec  = r_bytes_left - 16'd1;

    // Next state and event for the current item
    always_comb begin
        n_phase        = r_phase;
        n_record_size  = r_record_size;
        n_next_address = r_next_address;
        n_bytes_left   = r_bytes_left;
        o_result_valid = 1'b0;
        o_result       = '0;

        if (i_item.command == psl_pkg::CMD_RESTART) begin
            n_phase        = PH_SECTION;
            n_record_size  = '0;
            n_next_address = '0;
            n_bytes_left   = '0;
        end else if (i_item.command == psl_pkg::CMD_EOS && r_phase != PH_HALTED) begin
            o_result_valid = 1'b1;
            n_phase        = PH_HALTED;
            if (r_phase == PH_SECTION) begin
                o_result.event_kind = psl_pkg::EV_END;
            end else begin
                o_result.event_kind = psl_pkg::EV_ERROR;
                o_result.error_code = psl_pkg::ERR_READ;
            end
        end else if (i_item.command == psl_pkg::CMD_BYTE && r_phase != PH_HALTED) begin
            if (i_item.read_error) begin
                o_result_valid      = 1'b1;
                o_result.event_kind = psl_pkg::EV_ERROR;
                o_result.error_code = psl_pkg::ERR_READ;
                n_phase             = PH_HALTED;
            end else begin
                unique case (r_phase)
                    PH_SECTION: begin
                        // Data is tested first, then text, then term
                        if (i_item.byte_value == i_cfg.data_code) begin
                            n_phase = PH_SIZE_HI;
                        end else if (i_item.byte_value == i_cfg.text_code) begin
                            o_result_valid      = 1'b1;
                            o_result.event_kind = psl_pkg::EV_TEXT;
                            n_phase             = PH_HALTED;
                        end else if (i_item.byte_value == i_cfg.term_code) begin
                            o_result_valid      = 1'b1;
                            o_result.event_kind = psl_pkg::EV_END;
                            n_phase             = PH_HALTED;
                        end else begin
                            o_result_valid      = 1'b1;
                            o_result.event_kind = psl_pkg::EV_ERROR;
                            o_result.error_code = psl_pkg::ERR_SECTION;
                            n_phase             = PH_HALTED;
                        end
                    end
                    PH_SIZE_HI: begin
                        n_record_size = {i_item.byte_value, 8'd0};
                        n_phase       = PH_SIZE_LO;
                    end
                    PH_SIZE_LO: begin
                        n_record_size = w_size_full;
                        if (w_size_full == 16'd0) begin
                            o_result_valid      = 1'b1;
                            o_result.event_kind = psl_pkg::EV_DATAEND;
                            n_phase             = PH_SECTION;
                        end else begin
                            n_phase = PH_ADDR_HI;
                        end
                    end
                    PH_ADDR_HI: begin
                        n_next_address = {1'b0, i_item.byte_value, 8'd0};
                        n_phase        = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        n_next_address = {1'b0, w_addr_full};
                        if (w_addr_end > MEM_LIMIT) begin
                            o_result_valid      = 1'b1;
                            o_result.event_kind = psl_pkg::EV_ERROR;
                            o_result.error_code = psl_pkg::ERR_LARGE;
                            n_phase             = PH_HALTED;
                        end else begin
                            n_bytes_left = r_record_size;
                            n_phase      = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        o_result_valid         = 1'b1;
                        o_result.event_kind    = psl_pkg::EV_WRITE;
                        o_result.write_address = r_next_address[15:0];
                        o_result.write_data    = i_item.byte_value;
                        n_next_address         = r_next_address + 17'd1;
                        n_bytes_left           = w_left_dec;
                        if (w_left_dec == 16'd0) begin
                            n_phase = PH_SIZE_HI;
                        end
                    end
                    default: begin
                        n_phase = PH_HALTED;
                    end
                endcase
            end
        end
    end

    // Advance parser state on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SECTION;
            r_record_size  <= '0;
            r_next_address <= '0;
            r_bytes_left   <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_record_size  <= n_record_size;
            r_next_address <= n_next_address;
            r_bytes_left   <= n_bytes_left;
        end
    end

endmodule

// ===== sv/program_image_section_loader.sv =====
// ----------------------------------------------------------------------------
// program_image_section_loader
// Parses a byte-wide program image into memory writes and section events.
// ----------------------------------------------------------------------------
// The loader takes one image byte or command per cycle and, when the output
// side keeps up, delivers one event per cycle. The parser state is updated
// when an item leaves the input register and its event enters the output
// register. Items that cause no event (section opening bytes, record
// headers, restart) are dropped inside. The user must write the section
// codes through the configuration port only while the loader is idle; the
// loader does not enforce this. After a text hand-off, a program end or an
// error the loader ignores bytes and end-of-stream until a restart command.
module program_image_section_loader #(
    parameter int MEM_BYTES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    psl_in_if.sink           i_in,
    psl_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    psl_pkg::t_cfg    r_cfg;
    psl_pkg::t_item   r_item;
    logic             r_item_valid;
    psl_pkg::t_result r_result;
    logic             r_result_valid;

    psl_pkg::t_result w_result;
    logic             w_result_hit;
    logic             w_out_free;
    logic             w_step;

    // Output register can load when empty or being drained
    assign w_out_free = !r_result_valid || o_out.ready;
    assign w_step     = r_item_valid && w_out_free;
    assign i_in.ready = !r_item_valid || w_out_free;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_code <= psl_pkg::RST_DATA_CODE;
            r_cfg.text_code <= psl_pkg::RST_TEXT_CODE;
            r_cfg.term_code <= psl_pkg::RST_TERM_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psl_pkg::REG_DATA_CODE: r_cfg.data_code <= i_cfg_data;
                psl_pkg::REG_TEXT_CODE: r_cfg.text_code <= i_cfg_data;
                psl_pkg::REG_TERM_CODE: r_cfg.term_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: hold the item until the parser steps on it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_item_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.command    <= i_in.command;
            r_item.byte_value <= i_in.byte_value;
            r_item.read_error <= i_in.read_error;
        end
    end

    psl_parser #(
        .MEM_BYTES(MEM_BYTES)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_item         (r_item),
        .i_cfg          (r_cfg),
        .o_result_valid (w_result_hit),
        .o_result       (w_result)
    );

    // Output register: load events, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else if (w_out_free) begin
            r_result_valid <= w_step && w_result_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result_hit) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid         = r_result_valid;
    assign o_out.event_kind    = r_result.event_kind;
    assign o_out.write_address = r_result.write_address;
    assign o_out.write_data    = r_result.write_data;
    assign o_out.error_code    = r_result.error_code;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the program image section loader. A queue of
// image bytes and commands feeds a bursty input driver, a stalling sink
// takes the events, and an in-bench parser model predicts each event.
// Section codes change between phases while the loader is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int         MEM_BYTES     = 65536;
    localparam int         PHASES        = 8;
    localparam int         ITEMS_PER_PH  = 88;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         WATCHDOG_MAX  = 4000;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    typedef enum logic [2:0] {
        SEEK_SECTION,
        SIZE_HI,
        SIZE_LO,
        ADDR_HI,
        ADDR_LO,
        PAYLOAD,
        HALTED
    } t_parse_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    psl_in_if  in_if();
    psl_out_if out_if();

    program_image_section_loader #(
        .MEM_BYTES(MEM_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Parser model state and section codes
    t_parse_phase parse_phase = SEEK_SECTION;
    logic [15:0]  record_size = '0;
    logic [16:0]  next_address = '0;
    logic [15:0]  bytes_left = '0;
    logic [7:0]   data_code = psl_pkg::RST_DATA_CODE;
    logic [7:0]   text_code = psl_pkg::RST_TEXT_CODE;
    logic [7:0]   term_code = psl_pkg::RST_TERM_CODE;

    psl_pkg::t_item   pending_items[$];
    psl_pkg::t_result expected_events[$];
    int      stimulus_count = 0;
    int      failures = 0;
    int      idle_cycles = 0;
    logic    in_took = 1'b0;
    int      gap_left = 0;
    int      burst_left = 0;
    int      stall_left = 0;
    int      flow_left = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        failures++;
    endtask

    // Advance the parser model by one accepted transfer
    task automatic predict_event(input psl_pkg::t_item it);
        psl_pkg::t_result ev;
        logic    hit;
        ev  = '0;
        hit = 1'b0;
        if (it.command == psl_pkg::CMD_RESTART) begin
            parse_phase  = SEEK_SECTION;
            record_size  = '0;
            next_address = '0;
            bytes_left   = '0;
        end else if (it.command == CMD_UNUSED || parse_phase == HALTED) begin
            hit = 1'b0;
        end else if (it.command == psl_pkg::CMD_EOS) begin
            hit = 1'b1;
            if (parse_phase == SEEK_SECTION) begin
                ev.event_kind = psl_pkg::EV_END;
            end else begin
                ev.event_kind = psl_pkg::EV_ERROR;
                ev.error_code = psl_pkg::ERR_READ;
            end
            parse_phase = HALTED;
        end else if (it.read_error) begin
            hit = 1'b1;
            ev.event_kind = psl_pkg::EV_ERROR;
            ev.error_code = psl_pkg::ERR_READ;
            parse_phase = HALTED;
        end else begin
            case (parse_phase)
                SEEK_SECTION: begin
                    if (it.byte_value == data_code) begin
                        parse_phase = SIZE_HI;
                    end else begin
                        hit = 1'b1;
                        parse_phase = HALTED;
                        if (it.byte_value == text_code) begin
                            ev.event_kind = psl_pkg::EV_TEXT;
                        end else if (it.byte_value == term_code) begin
                            ev.event_kind = psl_pkg::EV_END;
                        end else begin
                            ev.event_kind = psl_pkg::EV_ERROR;
                            ev.error_code = psl_pkg::ERR_SECTION;
                        end
                    end
                end
                SIZE_HI: begin
                    record_size = {it.byte_value, 8'h00};
                    parse_phase = SIZE_LO;
                end
                SIZE_LO: begin
                    record_size = {record_size[15:8], it.byte_value};
                    if (record_size == 16'd0) begin
                        hit = 1'b1;
                        ev.event_kind = psl_pkg::EV_DATAEND;
                        parse_phase = SEEK_SECTION;
                    end else begin
                        parse_phase = ADDR_HI;
                    end
                end
                ADDR_HI: begin
                    next_address = {1'b0, it.byte_value, 8'h00};
                    parse_phase = ADDR_LO;
                end
                ADDR_LO: begin
                    next_address = {1'b0, next_address[15:8], it.byte_value};
                    if (int'(next_address) + int'(record_size) > MEM_BYTES) begin
                        hit = 1'b1;
                        ev.event_kind = psl_pkg::EV_ERROR;
                        ev.error_code = psl_pkg::ERR_LARGE;
                        parse_phase = HALTED;
                    end else begin
                        bytes_left = record_size;
                        parse_phase = PAYLOAD;
                    end
                end
                PAYLOAD: begin
                    hit = 1'b1;
                    ev.event_kind    = psl_pkg::EV_WRITE;
                    ev.write_address = next_address[15:0];
                    ev.write_data    = it.byte_value;
                    next_address = next_address + 17'd1;
                    bytes_left   = bytes_left - 16'd1;
                    if (bytes_left == 16'd0)
                        parse_phase = SIZE_HI;
                end
                default: begin
                    parse_phase = HALTED;
                end
            endcase
        end
        if (hit)
            expected_events.push_back(ev);
    endtask

    // Stimulus builders
    task automatic queue_item(input logic [1:0] cmd, input logic [7:0] b, input logic rerr);
        psl_pkg::t_item it;
        it.command    = cmd;
        it.byte_value = b;
        it.read_error = rerr;
        pending_items.push_back(it);
        if (cmd != CMD_UNUSED)
            stimulus_count++;
    endtask

    // Image byte, now and then preceded by a stray command and rarely a bad read
    task automatic queue_byte(input logic [7:0] b);
        if ($urandom_range(0, 49) == 0)
            queue_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
        queue_item(psl_pkg::CMD_BYTE, b, $urandom_range(0, 99) == 0);
    endtask

    task automatic queue_record();
        logic [15:0] size;
        logic [15:0] addr;
        int          roll;
        int          n_pay;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            size = 16'($urandom_range(1, 6));
        else if (roll < 95)
            size = 16'($urandom);
        else
            size = 16'($urandom_range(7, 40));
        if ($urandom_range(0, 4) == 0)
            addr = 16'hFFFF - 16'($urandom_range(0, 6));
        else
            addr = 16'($urandom);
        queue_byte(size[15:8]);
        queue_byte(size[7:0]);
        queue_byte(addr[15:8]);
        queue_byte(addr[7:0]);
        // Huge sizes get a short payload; the record is then cut off
        n_pay = (size > 16'd40) ? $urandom_range(0, 8) : int'(size);
        for (int i = 0; i < n_pay; i++)
            queue_byte(8'($urandom));
    endtask

    // One program: optional restart, a few sections, an optional end of stream
    task automatic queue_program();
        int n_sec;
        int roll;
        int n_rec;
        if ($urandom_range(0, 9) != 0)
            queue_item(psl_pkg::CMD_RESTART, 8'($urandom), 1'($urandom_range(0, 1)));
        n_sec = $urandom_range(1, 3);
        for (int s = 0; s < n_sec; s++) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                queue_byte(data_code);
                n_rec = $urandom_range(0, 4);
                for (int r = 0; r < n_rec; r++)
                    queue_record();
                if ($urandom_range(0, 9) == 0)
                    break;
                queue_byte(8'h00);
                queue_byte(8'h00);
            end else begin
                if (roll < 75)
                    queue_byte(text_code);
                else if (roll < 85)
                    queue_byte(term_code);
                else if (roll < 92)
                    queue_byte(8'($urandom));
                else
                    queue_item(psl_pkg::CMD_EOS, 8'($urandom), 1'($urandom_range(0, 1)));
                break;
            end
        end
        if ($urandom_range(0, 3) == 0)
            queue_item(psl_pkg::CMD_EOS, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_section_codes(input logic [7:0] d, input logic [7:0] t,
                                       input logic [7:0] e);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= psl_pkg::REG_DATA_CODE;
        i_cfg_data  <= d;
        @(negedge i_clk);
        i_cfg_index <= psl_pkg::REG_TEXT_CODE;
        i_cfg_data  <= t;
        @(negedge i_clk);
        i_cfg_index <= psl_pkg::REG_TERM_CODE;
        i_cfg_data  <= e;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        data_code = d;
        text_code = t;
        term_code = e;
    endtask

    task automatic wait_until_idle();
        while (pending_items.size() != 0 || in_if.valid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: bursts with random gaps, hold the item until it transfers
    always @(negedge i_clk) begin : drive_input
        psl_pkg::t_item next_item;
        logic  present;
        next_item = '0;
        present   = 1'b0;
        if (i_rst_n && (!in_if.valid || in_took)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                next_item = pending_items.pop_front();
                present   = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                             : $urandom_range(0, 2);
                end
            end
            in_if.valid <= present;
            if (present) begin
                in_if.command    <= next_item.command;
                in_if.byte_value <= next_item.byte_value;
                in_if.read_error <= next_item.read_error;
            end
        end
    end

    // Event sink: runs of ready broken by short and long stalls
    always @(negedge i_clk) begin : drive_ready
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (flow_left > 0) begin
            flow_left--;
            out_if.ready <= 1'b1;
        end else begin
            flow_left  = $urandom_range(0, 40);
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                     : $urandom_range(0, 2);
            out_if.ready <= 1'b1;
        end
    end

    // Check each event transfer, then predict from each input transfer
    always @(posedge i_clk) begin : monitor
        psl_pkg::t_result exp_ev;
        logic    out_fire;
        logic    in_fire;
        out_fire = out_if.valid && out_if.ready;
        in_fire  = in_if.valid && in_if.ready;
        if (out_fire) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event kind %0d addr %h data %h err %0d",
                                          out_if.event_kind, out_if.write_address,
                                          out_if.write_data, out_if.error_code));
            end else begin
                exp_ev = expected_events.pop_front();
                if (out_if.event_kind !== exp_ev.event_kind)
                    report_mismatch($sformatf("event_kind got %0d expected %0d",
                                              out_if.event_kind, exp_ev.event_kind));
                if (out_if.write_address !== exp_ev.write_address)
                    report_mismatch($sformatf("write_address got %h expected %h",
                                              out_if.write_address, exp_ev.write_address));
                if (out_if.write_data !== exp_ev.write_data)
                    report_mismatch($sformatf("write_data got %h expected %h",
                                              out_if.write_data, exp_ev.write_data));
                if (out_if.error_code !== exp_ev.error_code)
                    report_mismatch($sformatf("error_code got %0d expected %0d",
                                              out_if.error_code, exp_ev.error_code));
            end
        end
        if (in_fire) begin
            predict_event(psl_pkg::t_item'({in_if.command, in_if.byte_value,
                                            in_if.read_error}));
        end
        in_took <= in_fire;
        idle_cycles <= (in_fire || out_fire) ? 0 : idle_cycles + 1;
    end

    // Drop the run when nothing transfers for too long
    always @(posedge i_clk) begin : watchdog
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int target;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = psl_pkg::REG_DATA_CODE;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.command    = psl_pkg::CMD_BYTE;
        in_if.byte_value = '0;
        in_if.read_error = 1'b0;
        out_if.ready     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                // Hold the sender until every event is out, then change codes
                wait_until_idle();
                case (p)
                    1: write_section_codes(8'h00, 8'hFF, 8'h80);
                    2: write_section_codes(8'hFF, 8'h00, 8'hFF);
                    3: write_section_codes(8'h07, 8'h07, 8'h07);
                    4: write_section_codes(8'h80, 8'h40, 8'h40);
                    default: write_section_codes(8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
            if (p == 0) begin
                // One-byte record at the top address
                queue_item(psl_pkg::CMD_BYTE, psl_pkg::RST_DATA_CODE, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h01, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'hFF, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'hFF, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'hAB, 1'b0);
                // Two-byte record at the top address overruns memory
                queue_item(psl_pkg::CMD_BYTE, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h02, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'hFF, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'hFF, 1'b0);
                // Halted loader ignores end of stream; unused command after restart
                queue_item(psl_pkg::CMD_EOS, 8'h00, 1'b1);
                queue_item(psl_pkg::CMD_RESTART, 8'hFF, 1'b1);
                queue_item(CMD_UNUSED, 8'h5A, 1'b0);
                // Empty data section, then the terminator
                queue_item(psl_pkg::CMD_BYTE, psl_pkg::RST_DATA_CODE, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, psl_pkg::RST_TERM_CODE, 1'b0);
                // Unknown section byte
                queue_item(psl_pkg::CMD_RESTART, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h07, 1'b0);
                // End of stream at a boundary, then inside a record header
                queue_item(psl_pkg::CMD_RESTART, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_EOS, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_RESTART, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, psl_pkg::RST_DATA_CODE, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_EOS, 8'h00, 1'b0);
                // Bad read on a section byte
                queue_item(psl_pkg::CMD_RESTART, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, psl_pkg::RST_TEXT_CODE, 1'b1);
            end
            if (p == 1) begin
                // Largest record here: 256 bytes ending exactly at the memory top
                queue_item(psl_pkg::CMD_RESTART, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, data_code, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h01, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'hFF, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h00, 1'b0);
                for (int i = 0; i < 256; i++)
                    queue_item(psl_pkg::CMD_BYTE, 8'($urandom), 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h00, 1'b0);
                queue_item(psl_pkg::CMD_BYTE, 8'h00, 1'b0);
            end
            target = stimulus_count + ITEMS_PER_PH;
            while (stimulus_count < target)
                queue_program();
        end

        wait_until_idle();
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
